// File: hw/rtl/ktap_pkg.sv
package ktap_pkg;

    localparam int ANG_W    = 40;
    localparam int ATAN_LEN = 40;

    typedef logic signed [ANG_W-1:0] ang_t;

    localparam ang_t PI_Q30       = 40'sd3373259426;
    localparam ang_t HALF_PI_Q30  = 40'sd1686629713;
    localparam ang_t TWO_PI_Q30   = 40'sd6746518852;
    localparam ang_t INV_GAIN_Q30 = 40'sd652032874;

    localparam logic [0:0] REG_ECC = 1'b0;
    localparam logic [0:0] REG_TOL = 1'b1;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_SQRT_M,
        OP_SQRT_P,
        OP_WRAP,
        OP_SINCOS,
        OP_ATAN,
        OP_MUL_S_SQM,
        OP_MUL_C_SQP,
        OP_MUL_S_SQP,
        OP_MUL_C_SQM,
        OP_MUL_ES,
        OP_PUT_Y,
        OP_PUT_X,
        OP_PUT_ES,
        OP_E_FROM_Z,
        OP_ANG_FROM_E,
        OP_ANG_HALF_E,
        OP_ANG_FROM_Z2,
        OP_M_INIT,
        OP_CHECK,
        OP_E_UPDATE,
        OP_OUT
    } op_t;

    typedef struct packed {
        logic start;
        logic load;
        logic nc;
        op_t  op;
    } cmd_t;

    typedef struct packed {
        logic done;
        logic conv;
    } sts_t;

    // floor(atan(2^-i) * 2^30)
    function automatic logic [30:0] atan_q30(input logic [5:0] idx);
        logic [30:0] r;
        unique case (idx)
            6'd0:  r = 31'h3243F6A8;
            6'd1:  r = 31'h1DAC6705;
            6'd2:  r = 31'h0FADBAFC;
            6'd3:  r = 31'h07F56EA6;
            6'd4:  r = 31'h03FEAB76;
            6'd5:  r = 31'h01FFD55B;
            6'd6:  r = 31'h00FFFAAA;
            6'd7:  r = 31'h007FFF55;
            6'd8:  r = 31'h003FFFEA;
            6'd9:  r = 31'h001FFFFD;
            6'd10: r = 31'h000FFFFF;
            6'd11: r = 31'h0007FFFF;
            6'd12: r = 31'h0003FFFF;
            6'd13: r = 31'h0001FFFF;
            6'd14: r = 31'h0000FFFF;
            6'd15: r = 31'h00007FFF;
            6'd16: r = 31'h00003FFF;
            6'd17: r = 31'h00001FFF;
            6'd18: r = 31'h00000FFF;
            6'd19: r = 31'h000007FF;
            6'd20: r = 31'h000003FF;
            6'd21: r = 31'h000001FF;
            6'd22: r = 31'h000000FF;
            6'd23: r = 31'h0000007F;
            6'd24: r = 31'h0000003F;
            6'd25: r = 31'h0000001F;
            6'd26: r = 31'h0000000F;
            6'd27: r = 31'h00000007;
            6'd28: r = 31'h00000003;
            6'd29: r = 31'h00000001;
            default: r = 31'h0;
        endcase
        return r;
    endfunction

endpackage

// File: hw/rtl/ktap_cordic.sv
module ktap_cordic #(
    parameter int STAGES = 28
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic            vec,
    input  ktap_pkg::ang_t  x0,
    input  ktap_pkg::ang_t  y0,
    input  ktap_pkg::ang_t  z0,
    output logic            done,
    output ktap_pkg::ang_t  x,
    output ktap_pkg::ang_t  y,
    output ktap_pkg::ang_t  z
);

    localparam int N  = (STAGES < ktap_pkg::ATAN_LEN) ? STAGES : ktap_pkg::ATAN_LEN;
    localparam int IW = $clog2(N);

    ktap_pkg::ang_t x_reg, y_reg, z_reg;
    ktap_pkg::ang_t x_next, y_next, z_next, dx, dy, a;
    logic [IW-1:0]  i_reg;
    logic           busy_reg, done_reg, vec_reg, neg_reg, zero_reg, ccw;

    always_comb
    begin
        dx  = x_reg;
        dy  = y_reg;
        dx  = y_reg >>> i_reg;
        dy  = x_reg >>> i_reg;
        a   = ktap_pkg::ang_t'(ktap_pkg::atan_q30(6'(i_reg)));
        ccw = vec_reg ? !(y_reg > 0) : (z_reg >= 0);
        if (ccw)
        begin
            x_next = x_reg - dx;
            y_next = y_reg + dy;
            z_next = z_reg - a;
        end
        else
        begin
            x_next = x_reg + dx;
            y_next = y_reg - dy;
            z_next = z_reg + a;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            vec_reg  <= 1'b0;
            neg_reg  <= 1'b0;
            zero_reg <= 1'b0;
            i_reg    <= '0;
            x_reg    <= '0;
            y_reg    <= '0;
            z_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                vec_reg  <= vec;
                i_reg    <= '0;
                neg_reg  <= 1'b0;
                zero_reg <= vec && (x0 == 0) && (y0 == 0);
                x_reg    <= x0;
                y_reg    <= y0;
                z_reg    <= z0;
                if (vec)
                begin
                    // pre-rotation by a quarter turn for the left half-plane
                    if (x0 < 0)
                    begin
                        if (y0 >= 0)
                        begin
                            x_reg <= y0;
                            y_reg <= -x0;
                            z_reg <= ktap_pkg::HALF_PI_Q30;
                        end
                        else
                        begin
                            x_reg <= -y0;
                            y_reg <= x0;
                            z_reg <= -ktap_pkg::HALF_PI_Q30;
                        end
                    end
                end
                else if (z0 > ktap_pkg::HALF_PI_Q30)
                begin
                    z_reg   <= z0 - ktap_pkg::PI_Q30;
                    neg_reg <= 1'b1;
                end
                else if (z0 < -ktap_pkg::HALF_PI_Q30)
                begin
                    z_reg   <= z0 + ktap_pkg::PI_Q30;
                    neg_reg <= 1'b1;
                end
            end
            else if (busy_reg)
            begin
                x_reg <= x_next;
                y_reg <= y_next;
                z_reg <= z_next;
                i_reg <= i_reg + 1'b1;
                if (i_reg == IW'(N - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    if (neg_reg)
                    begin
                        x_reg <= -x_next;
                        y_reg <= -y_next;
                    end
                    if (zero_reg)
                    begin
                        z_reg <= '0;
                    end
                end
            end
        end
    end

    assign done = done_reg;
    assign x    = x_reg;
    assign y    = y_reg;
    assign z    = z_reg;

endmodule

// File: hw/rtl/ktap_isqrt.sv
module ktap_isqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] val,
    output logic        done,
    output logic [30:0] root
);

    logic [63:0] v_reg, res_reg, bit_reg, tmp;
    logic        busy_reg, done_reg;

    assign tmp = res_reg + bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            v_reg    <= '0;
            res_reg  <= '0;
            bit_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                v_reg    <= val;
                res_reg  <= '0;
                bit_reg  <= 64'h4000_0000_0000_0000;
            end
            else if (busy_reg)
            begin
                // one result bit per cycle
                if (v_reg >= tmp)
                begin
                    v_reg   <= v_reg - tmp;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                if (bit_reg == 64'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = res_reg[30:0];

endmodule

// File: hw/rtl/ktap_dp.sv
module ktap_dp #(
    parameter int CORDIC_STAGES = 28
) (
    input  logic            clk,
    input  logic            rst_n,
    input  ktap_pkg::cmd_t  cmd,
    output ktap_pkg::sts_t  sts,
    input  logic [63:0]     in_data,
    output logic [31:0]     out_data,
    input  logic            cfg_we,
    input  logic [0:0]      cfg_addr,
    input  logic [31:0]     cfg_wdata
);

    ktap_pkg::ang_t ang_reg, step_reg, e_reg, m_reg, es_reg, yv_reg, xv_reg, z_reg;
    logic signed [31:0] s_reg, c_reg, f1;
    logic [31:0]        ecc_reg, f2, out_reg;
    logic [15:0]        tol_reg;
    logic [30:0]        sqm_reg, sqp_reg, root;
    logic signed [63:0] prod_reg;
    logic signed [64:0] prod_full;
    logic [32:0]        one_minus, one_plus;
    logic [63:0]        sq_val;
    logic               wrap_busy_reg, wrap_done, in_range, sq_start, sq_done;
    logic               cor_start, cor_done, cor_vec;
    ktap_pkg::ang_t     cx, cy, cz, cx0, cy0, cz0, resid, resid_abs, rounded;

    // (2^32 -+ e) >> 2 << 30
    assign one_minus = 33'h1_0000_0000 - {1'b0, ecc_reg};
    assign one_plus  = 33'h1_0000_0000 + {1'b0, ecc_reg};
    assign sq_val    = (cmd.op == ktap_pkg::OP_SQRT_M) ? {3'b0, one_minus[32:2], 30'b0}
                                                      : {3'b0, one_plus[32:2], 30'b0};
    assign sq_start  = cmd.start && (cmd.op == ktap_pkg::OP_SQRT_M ||
                                     cmd.op == ktap_pkg::OP_SQRT_P);

    ktap_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .val   (sq_val),
        .done  (sq_done),
        .root  (root)
    );

    assign cor_vec   = (cmd.op == ktap_pkg::OP_ATAN);
    assign cor_start = cmd.start && (cmd.op == ktap_pkg::OP_SINCOS || cor_vec);
    assign cx0       = cor_vec ? xv_reg : ktap_pkg::INV_GAIN_Q30;
    assign cy0       = cor_vec ? yv_reg : '0;
    assign cz0       = cor_vec ? '0 : ang_reg;

    ktap_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cor_start),
        .vec   (cor_vec),
        .x0    (cx0),
        .y0    (cy0),
        .z0    (cz0),
        .done  (cor_done),
        .x     (cx),
        .y     (cy),
        .z     (cz)
    );

    always_comb
    begin
        f1 = s_reg;
        f2 = ecc_reg;
        unique case (cmd.op)
            ktap_pkg::OP_MUL_S_SQM: begin f1 = s_reg; f2 = {1'b0, sqm_reg}; end
            ktap_pkg::OP_MUL_C_SQP: begin f1 = c_reg; f2 = {1'b0, sqp_reg}; end
            ktap_pkg::OP_MUL_S_SQP: begin f1 = s_reg; f2 = {1'b0, sqp_reg}; end
            ktap_pkg::OP_MUL_C_SQM: begin f1 = c_reg; f2 = {1'b0, sqm_reg}; end
            default:                begin f1 = s_reg; f2 = ecc_reg;         end
        endcase
    end

    assign prod_full = f1 * $signed({1'b0, f2});

    assign in_range  = (ang_reg <= ktap_pkg::PI_Q30) && (ang_reg > -ktap_pkg::PI_Q30);
    assign wrap_done = wrap_busy_reg && in_range;

    assign resid     = e_reg - es_reg - m_reg;
    assign resid_abs = (resid < 0) ? -resid : resid;
    assign rounded   = (ang_reg + 40'sd2) >>> 2;

    assign sts.done = sq_done || cor_done || wrap_done;
    assign sts.conv = (resid_abs <= $signed({22'b0, tol_reg, 2'b0}));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ecc_reg       <= '0;
            tol_reg       <= 16'd3;
            wrap_busy_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    ktap_pkg::REG_ECC: ecc_reg <= cfg_wdata;
                    ktap_pkg::REG_TOL: tol_reg <= cfg_wdata[15:0];
                endcase
            end
            if (cmd.start && cmd.op == ktap_pkg::OP_WRAP)
            begin
                wrap_busy_reg <= 1'b1;
            end
            else if (wrap_done)
            begin
                wrap_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ang_reg  <= ktap_pkg::ang_t'($signed(in_data[31:0])) <<< 1;
            step_reg <= ktap_pkg::ang_t'($signed(in_data[63:32])) <<< 2;
        end
        if (wrap_busy_reg && !in_range)
        begin
            if (ang_reg > ktap_pkg::PI_Q30)
            begin
                ang_reg <= ang_reg - ktap_pkg::TWO_PI_Q30;
            end
            else
            begin
                ang_reg <= ang_reg + ktap_pkg::TWO_PI_Q30;
            end
        end
        if (sq_done)
        begin
            if (cmd.op == ktap_pkg::OP_SQRT_M)
            begin
                sqm_reg <= root;
            end
            else
            begin
                sqp_reg <= root;
            end
        end
        if (cor_done)
        begin
            if (cor_vec)
            begin
                z_reg <= cz;
            end
            else
            begin
                s_reg <= cy[31:0];
                c_reg <= cx[31:0];
            end
        end
        if (cmd.start)
        begin
            unique case (cmd.op)
                ktap_pkg::OP_MUL_S_SQM,
                ktap_pkg::OP_MUL_C_SQP,
                ktap_pkg::OP_MUL_S_SQP,
                ktap_pkg::OP_MUL_C_SQM,
                ktap_pkg::OP_MUL_ES:      prod_reg <= prod_full[63:0];
                ktap_pkg::OP_PUT_Y:       yv_reg   <= ktap_pkg::ang_t'(prod_reg >>> 30);
                ktap_pkg::OP_PUT_X:       xv_reg   <= ktap_pkg::ang_t'(prod_reg >>> 30);
                ktap_pkg::OP_PUT_ES:      es_reg   <= ktap_pkg::ang_t'(prod_reg >>> 32);
                ktap_pkg::OP_E_FROM_Z:    e_reg    <= z_reg <<< 1;
                ktap_pkg::OP_ANG_FROM_E:  ang_reg  <= e_reg;
                ktap_pkg::OP_ANG_HALF_E:  ang_reg  <= e_reg >>> 1;
                ktap_pkg::OP_ANG_FROM_Z2: ang_reg  <= z_reg <<< 1;
                ktap_pkg::OP_M_INIT:      m_reg    <= e_reg - es_reg + step_reg;
                ktap_pkg::OP_E_UPDATE:    e_reg    <= m_reg + es_reg;
                ktap_pkg::OP_OUT:         out_reg  <= {cmd.nc, rounded[30:0]};
                default:                  ;
            endcase
        end
    end

    assign out_data = out_reg;

endmodule

// File: hw/rtl/ktap_ctrl.sv
module ktap_ctrl #(
    parameter int MAX_ITERATIONS = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    output ktap_pkg::cmd_t  cmd,
    input  ktap_pkg::sts_t  sts
);

    localparam int KW = $clog2(MAX_ITERATIONS + 1);
    localparam logic [5:0] PC_LOOP  = 6'd16;
    localparam logic [5:0] PC_FINAL = 6'd23;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_WAIT
    } state_t;

    state_t         state_reg;
    logic [5:0]     pc_reg;
    logic [KW-1:0]  k_reg;
    logic           nc_reg, out_valid_reg, long_op, out_block;
    ktap_pkg::op_t  op;

    // micro-program: set-up, Kepler loop, conversion back
    function automatic ktap_pkg::op_t ucode(input logic [5:0] pc);
        ktap_pkg::op_t r;
        unique case (pc)
            6'd0:  r = ktap_pkg::OP_SQRT_M;
            6'd1:  r = ktap_pkg::OP_SQRT_P;
            6'd2:  r = ktap_pkg::OP_WRAP;
            6'd3:  r = ktap_pkg::OP_SINCOS;
            6'd4:  r = ktap_pkg::OP_MUL_S_SQM;
            6'd5:  r = ktap_pkg::OP_PUT_Y;
            6'd6:  r = ktap_pkg::OP_MUL_C_SQP;
            6'd7:  r = ktap_pkg::OP_PUT_X;
            6'd8:  r = ktap_pkg::OP_ATAN;
            6'd9:  r = ktap_pkg::OP_E_FROM_Z;
            6'd10: r = ktap_pkg::OP_ANG_FROM_E;
            6'd11: r = ktap_pkg::OP_WRAP;
            6'd12: r = ktap_pkg::OP_SINCOS;
            6'd13: r = ktap_pkg::OP_MUL_ES;
            6'd14: r = ktap_pkg::OP_PUT_ES;
            6'd15: r = ktap_pkg::OP_M_INIT;
            6'd16: r = ktap_pkg::OP_ANG_FROM_E;
            6'd17: r = ktap_pkg::OP_WRAP;
            6'd18: r = ktap_pkg::OP_SINCOS;
            6'd19: r = ktap_pkg::OP_MUL_ES;
            6'd20: r = ktap_pkg::OP_PUT_ES;
            6'd21: r = ktap_pkg::OP_CHECK;
            6'd22: r = ktap_pkg::OP_E_UPDATE;
            6'd23: r = ktap_pkg::OP_ANG_HALF_E;
            6'd24: r = ktap_pkg::OP_WRAP;
            6'd25: r = ktap_pkg::OP_SINCOS;
            6'd26: r = ktap_pkg::OP_MUL_S_SQP;
            6'd27: r = ktap_pkg::OP_PUT_Y;
            6'd28: r = ktap_pkg::OP_MUL_C_SQM;
            6'd29: r = ktap_pkg::OP_PUT_X;
            6'd30: r = ktap_pkg::OP_ATAN;
            6'd31: r = ktap_pkg::OP_ANG_FROM_Z2;
            6'd32: r = ktap_pkg::OP_WRAP;
            6'd33: r = ktap_pkg::OP_OUT;
            default: r = ktap_pkg::OP_NOP;
        endcase
        return r;
    endfunction

    assign op        = ucode(pc_reg);
    assign long_op   = (op == ktap_pkg::OP_SQRT_M) || (op == ktap_pkg::OP_SQRT_P) ||
                       (op == ktap_pkg::OP_WRAP)   || (op == ktap_pkg::OP_SINCOS) ||
                       (op == ktap_pkg::OP_ATAN);
    assign out_block = (op == ktap_pkg::OP_OUT) && out_valid_reg && !out_ready;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    assign cmd.start = (state_reg == ST_RUN) && !out_block;
    assign cmd.load  = (state_reg == ST_IDLE) && in_valid;
    assign cmd.nc    = nc_reg;
    assign cmd.op    = op;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= '0;
            k_reg         <= '0;
            nc_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= ST_RUN;
                        pc_reg    <= '0;
                        k_reg     <= '0;
                        nc_reg    <= 1'b0;
                    end
                end
                ST_RUN:
                begin
                    priority if (op == ktap_pkg::OP_OUT)
                    begin
                        if (!out_block)
                        begin
                            out_valid_reg <= 1'b1;
                            state_reg     <= ST_IDLE;
                        end
                    end
                    else if (long_op)
                    begin
                        state_reg <= ST_WAIT;
                    end
                    else if (op == ktap_pkg::OP_CHECK)
                    begin
                        priority if (sts.conv)
                        begin
                            pc_reg <= PC_FINAL;
                        end
                        else if (k_reg == KW'(MAX_ITERATIONS))
                        begin
                            nc_reg <= 1'b1;
                            pc_reg <= PC_FINAL;
                        end
                        else
                        begin
                            k_reg  <= k_reg + 1'b1;
                            pc_reg <= pc_reg + 1'b1;
                        end
                    end
                    else if (op == ktap_pkg::OP_E_UPDATE)
                    begin
                        pc_reg <= PC_LOOP;
                    end
                    else
                    begin
                        pc_reg <= pc_reg + 1'b1;
                    end
                end
                ST_WAIT:
                begin
                    if (sts.done)
                    begin
                        pc_reg    <= pc_reg + 1'b1;
                        state_reg <= ST_RUN;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// File: hw/rtl/kepler_true_anomaly_propagate.sv
// kepler true-anomaly propagator
// one transaction on the slave stream carries a starting true anomaly and a
// mean-anomaly step (both signed q3.28 radians); one transaction on the master
// stream returns the propagated true anomaly wrapped into (-pi, pi] and a flag
// set when the kepler iteration hit its cap before meeting the tolerance
// eccentricity and tolerance must be written through the cfg port only while
// idle; the block itself does not enforce this
// one item at a time: a micro-sequenced controller drives one shared cordic
// (one stage per cycle), one bit-serial square root, one 32x33 multiplier and
// a wrap unit; an item costs two square roots, five cordic passes and the glue
// steps, then one cordic pass per residual check, plus the extra wrap steps,
// with 65 checks in the worst case at MAX_ITERATIONS=64
// the next transaction is taken as soon as a result sits in the output
// register; if the receiver stalls the block finishes the next item and
// waits before writing it out
// reset clears the controller, drops tvalid and sets eccentricity 0, tolerance 3
module kepler_true_anomaly_propagate #(
    parameter int MAX_ITERATIONS = 64,
    parameter int CORDIC_STAGES  = 28
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] true_anomaly, [63:32] mean_anomaly_step
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [30:0] new_true_anomaly, [31] not_converged
    input  logic        cfg_we,
    input  logic [0:0]  cfg_addr,       // 0 eccentricity, 1 tolerance
    input  logic [31:0] cfg_wdata
);

    ktap_pkg::cmd_t cmd;
    ktap_pkg::sts_t sts;

    // sequencer: walks the micro-program and owns the stream handshakes
    ktap_ctrl #(.MAX_ITERATIONS(MAX_ITERATIONS)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // datapath: angle registers, shared arithmetic units, result register
    ktap_dp #(.CORDIC_STAGES(CORDIC_STAGES)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (s_axis_tdata),
        .out_data  (m_axis_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

endmodule

// File: tb/kepler_true_anomaly_propagate_tb.sv
module kepler_true_anomaly_propagate_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_ITER = 64;
    localparam int STAGES   = 28;

    // expected propagation result and the orbit settings that shape it
    class kepler_scoreboard;
        typedef struct {
            logic [30:0] anomaly;
            logic        nc;
        } result_t;

        result_t     pending[$];
        logic [31:0] ecc;
        logic [15:0] tol;
        int          mismatches;
        longint      atan_tab[30];

        function new();
            ecc = 0;
            tol = 3;
            mismatches = 0;
            atan_tab = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
                         64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
                         64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
                         64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
                         64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
                         64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
                         64'h0000003F, 64'h0000001F, 64'h0000000F, 64'h00000007,
                         64'h00000003, 64'h00000001};
        endfunction

        function longint tab(int i);
            return (i < 30) ? atan_tab[i] : 64'sd0;
        endfunction

        function longint wrap(longint v);
            longint r;
            r = v % longint'(ktap_pkg::TWO_PI_Q30);
            if (r > longint'(ktap_pkg::PI_Q30))
                r -= longint'(ktap_pkg::TWO_PI_Q30);
            else if (r <= -longint'(ktap_pkg::PI_Q30))
                r += longint'(ktap_pkg::TWO_PI_Q30);
            return r;
        endfunction

        function void rotate(longint a, output longint s, output longint c);
            longint z, x, y, dx, dy;
            bit neg;
            z = wrap(a);
            x = longint'(ktap_pkg::INV_GAIN_Q30);
            y = 0;
            neg = 0;
            if (z > longint'(ktap_pkg::HALF_PI_Q30))
            begin
                z -= longint'(ktap_pkg::PI_Q30);
                neg = 1;
            end
            else if (z < -longint'(ktap_pkg::HALF_PI_Q30))
            begin
                z += longint'(ktap_pkg::PI_Q30);
                neg = 1;
            end
            for (int i = 0; i < STAGES; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0)
                begin
                    x -= dx; y += dy; z -= tab(i);
                end
                else
                begin
                    x += dx; y -= dy; z += tab(i);
                end
            end
            if (neg)
            begin
                x = -x; y = -y;
            end
            s = y;
            c = x;
        endfunction

        function longint vector_angle(longint y, longint x);
            longint z, t, dx, dy;
            z = 0;
            if (x == 0 && y == 0)
                return 0;
            if (x < 0)
            begin
                t = x;
                if (y >= 0)
                begin
                    x = y; y = -t; z = longint'(ktap_pkg::HALF_PI_Q30);
                end
                else
                begin
                    x = -y; y = t; z = -longint'(ktap_pkg::HALF_PI_Q30);
                end
            end
            for (int i = 0; i < STAGES; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (y > 0)
                begin
                    x += dx; y -= dy; z += tab(i);
                end
                else
                begin
                    x -= dx; y += dy; z -= tab(i);
                end
            end
            return z;
        endfunction

        function longint root(longint unsigned v);
            longint unsigned res, bitv;
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > v)
                bitv >>= 2;
            while (bitv != 0)
            begin
                if (v >= res + bitv)
                begin
                    v -= res + bitv;
                    res = (res >> 1) + bitv;
                end
                else
                    res >>= 1;
                bitv >>= 2;
            end
            return longint'(res);
        endfunction

        function longint ecc_sin(longint a);
            longint s, c;
            rotate(a, s, c);
            return (longint'({32'b0, ecc}) * s) >>> 32;
        endfunction

        function void note(logic [31:0] ta, logic [31:0] stp);
            longint unsigned one;
            longint sqm, sqp, f, dm, tl, s, c, e, m, es, r, v;
            result_t res;
            one = 64'h1_0000_0000;
            sqm = root(((one - ecc) >> 2) << 30);
            sqp = root(((one + ecc) >> 2) << 30);
            f = $signed(ta);
            f = f * 4;
            dm = $signed(stp);
            dm = dm * 4;
            tl = longint'(tol) * 4;
            res.nc = 0;
            rotate(f >>> 1, s, c);
            e = 2 * vector_angle((s * sqm) >>> 30, (c * sqp) >>> 30);
            m = e - ecc_sin(e) + dm;
            for (int k = 0;; k++)
            begin
                es = ecc_sin(e);
                r = e - es - m;
                if (r < 0)
                    r = -r;
                if (r <= tl)
                    break;
                if (k >= MAX_ITER)
                begin
                    res.nc = 1;
                    break;
                end
                e = m + es;
            end
            rotate(e >>> 1, s, c);
            v = wrap(2 * vector_angle((s * sqp) >>> 30, (c * sqm) >>> 30));
            v = (v + 2) >>> 2;
            res.anomaly = v[30:0];
            pending.push_back(res);
        endfunction

        function void check(logic [31:0] d);
            result_t exp_r;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction %h", d);
                return;
            end
            exp_r = pending.pop_front();
            if (d[30:0] !== exp_r.anomaly || d[31] !== exp_r.nc)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: anomaly exp %h got %h, nc exp %b got %b",
                             exp_r.anomaly, d[30:0], exp_r.nc, d[31]);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // [31:0] true_anomaly, [63:32] mean_anomaly_step
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // [30:0] new_true_anomaly, [31] not_converged
    logic        cfg_we;
    logic [0:0]  cfg_addr;
    logic [31:0] cfg_wdata;

    kepler_scoreboard sb;

    // no idling on either side while this is set
    bit steady;
    // receiver hold-off request and its own cycle count
    bit hold_go;
    bit hold_done;
    int hold_cnt;

    kepler_true_anomaly_propagate #(
        .MAX_ITERATIONS(MAX_ITER),
        .CORDIC_STAGES (STAGES)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata)
    );

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    // receiver side: random stalls, plus one long hold-off so the block backs up
    initial
    begin
        m_axis_tready = 0;
        hold_cnt = 0;
        hold_done = 0;
        forever
        begin
            @(posedge clk);
            if (hold_go && !hold_done)
            begin
                m_axis_tready <= 0;
                hold_cnt++;
                if (hold_cnt >= 8000)
                    hold_done = 1;
            end
            else if (steady)
                m_axis_tready <= 1;
            else
                m_axis_tready <= ($urandom_range(0, 99) >= 19);
        end
    end

    // result transaction monitor
    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check(m_axis_tdata);

    task automatic write_reg(logic [0:0] idx, logic [31:0] val);
        @(posedge clk);
        cfg_we    <= 1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 0;
        if (idx == ktap_pkg::REG_ECC)
            sb.ecc = val;
        else
            sb.tol = val[15:0];
    endtask

    // offer one input transaction, then maybe idle for a while
    task automatic send_item(logic [31:0] ta, logic [31:0] stp);
        s_axis_tvalid <= 1;
        s_axis_tdata  <= {stp, ta};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note(ta, stp);
        if (!steady && $urandom_range(0, 99) < 19)
        begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // half in-range angles, the other half anything the 32 bits allow
    function automatic logic [31:0] rand_angle();
        if ($urandom_range(0, 1))
            return $urandom;
        return 32'($signed($urandom_range(0, 1686629714)) - 843314857);
    endfunction

    logic [31:0] ecc_set[6] = '{32'hFFFFFFFF, 32'h80000000, 32'h19999999,
                                32'hE6666666, 32'h00000000, 32'h40000000};
    logic [31:0] tol_set[6] = '{32'd1, 32'd3, 32'd0, 32'd65535, 32'd1, 32'd200};

    logic [31:0] dir_ta[16] = '{32'h0, 32'h7FFFFFFF, 32'h80000000, 32'd843314857,
                                -32'sd843314857, 32'd421657428, 32'h1, 32'hFFFFFFFF,
                                32'h0, 32'h55555555, 32'hAAAAAAAA, 32'd843314857,
                                32'h7FFFFFFF, 32'h80000000, 32'h0, -32'sd421657428};
    logic [31:0] dir_st[16] = '{32'h0, 32'h0, 32'h0, 32'h0,
                                32'h0, 32'h0, 32'h7FFFFFFF, 32'h80000000,
                                32'd843314857, 32'hAAAAAAAA, 32'h55555555, 32'd843314857,
                                32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 32'h1};

    initial
    begin
        sb = new();
        rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = 0;
        cfg_we = 0;
        cfg_addr = ktap_pkg::REG_ECC;
        cfg_wdata = 0;
        steady = 0;
        hold_go = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed items under reset settings
        for (int i = 0; i < 16; i++)
            send_item(dir_ta[i], dir_st[i]);
        drain();

        for (int p = 0; p < 7; p++)
        begin
            if (p < 6)
            begin
                write_reg(ktap_pkg::REG_ECC, ecc_set[p]);
                write_reg(ktap_pkg::REG_TOL, tol_set[p]);
            end
            else
            begin
                write_reg(ktap_pkg::REG_ECC, $urandom);
                write_reg(ktap_pkg::REG_TOL, $urandom_range(1, 65535));
            end
            // near-one eccentricity: the half-turn angle drives a zero vector
            if (p == 0)
                send_item(32'd843314857, 32'h0);
            steady = (p == 2);
            if (p == 1)
                hold_go = 1;
            for (int i = 0; i < 39; i++)
                send_item(rand_angle(), rand_angle());
            drain();
        end
        steady = 0;

        if (sb.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #40ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
